>>> rtl/sem_pkg.sv
// shared constants, types and kernel helpers for the sobel edge magnitude block
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 10;
    localparam int SQ_W      = 18;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);
    localparam int                 MIN_DIM      = 3;
    localparam logic [SQ_W-1:0]    ROOT_START   = SQ_W'(1) << 16;
    localparam logic [PIX_W-1:0]   MAG_MAX      = PIX_W'(255);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic signed [2:0] t_coef;

    localparam t_coef KX [0:8] = '{-3'sd1, 3'sd0, 3'sd1,
                                   -3'sd2, 3'sd0, 3'sd2,
                                   -3'sd1, 3'sd0, 3'sd1};
    localparam t_coef KY [0:8] = '{-3'sd1, -3'sd2, -3'sd1,
                                    3'sd0,  3'sd0,  3'sd0,
                                    3'sd1,  3'sd2,  3'sd1};

    typedef struct packed {
        logic capture;
        logic load;
        logic square;
        logic root_step;
        logic out_load;
    } t_sem_cmd;

    typedef struct packed {
        logic has_result;
        logic root_last;
        logic out_free;
    } t_sem_stat;

    // pixel times coefficient, floored by 4
    function automatic logic signed [GRAD_W-1:0] sobel_term(input logic [PIX_W-1:0] p,
                                                            input t_coef k);
        logic signed [PIX_W+2:0] prod;
        prod = $signed({3'b000, p}) * k;
        return GRAD_W'(prod >>> 2);
    endfunction

endpackage

`default_nettype wire

>>> rtl/sem_pix_if.sv
// pixel request channel
`default_nettype none

interface sem_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

>>> rtl/sem_mag_if.sv
// edge magnitude result channel
`default_nettype none

interface sem_mag_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_magnitude;
    logic       row_last;

    modport source (output valid, output edge_magnitude, output row_last, input ready);
    modport sink   (input valid, input edge_magnitude, input row_last, output ready);
endinterface

`default_nettype wire

>>> rtl/sobel_edge_magnitude_top.sv
// Streaming 3x3 Sobel edge magnitude over 8-bit grayscale pixels in raster order. Each
// accepted pixel request reads and rewrites two line stores and shifts the 3x3
// window; once the window is full it yields floor(sqrt(gx^2 + gy^2)) clamped to 255 for the
// window centre, with row_last on the final result of a row. A pixel that produces no result
// occupies the block through its accept and the registered line store read and write; a
// pixel with a result also passes the squaring step and the 9-step bit-per-cycle square
// root unit, then waits until the output register is free. The next pixel may be accepted
// while a finished result still sits in the output register. Line stores are not cleared at
// reset and need no clearing pass. Configuration writes (image width, image height) take
// effect immediately and are meant to happen while the block is idle.
`default_nettype none

module sobel_edge_magnitude_top import sem_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    sem_pix_if.sink                   i_pix,
    sem_mag_if.source                 o_mag,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_sem_cmd  cmd;
    t_sem_stat stat;
    logic      in_ready;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sem_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mag_valid   (o_mag.valid),
        .o_mag         (o_mag.edge_magnitude),
        .o_row_last    (o_mag.row_last),
        .i_mag_ready   (o_mag.ready)
    );

    assign i_pix.ready = in_ready;

endmodule

`default_nettype wire

>>> rtl/sem_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module sem_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sem_dp.sv
// datapath: counters, line stores, window, gradients, square root and output register
`default_nettype none

module sem_dp import sem_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_sem_cmd             i_cmd,
    output t_sem_stat                 o_stat,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire logic                 i_frame_start,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_mag_valid,
    output logic [PIX_W-1:0]          o_mag,
    output logic                      o_row_last,
    input  wire logic                 i_mag_ready
);

    logic [IMG_W_W-1:0]      r_img_w;
    logic [IMG_H_W-1:0]      r_img_h;
    logic [COL_W-1:0]        r_col, n_col;
    logic [IMG_H_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]        r_c;
    logic [PIX_W-1:0]        r_pix;
    logic                    r_has_res;
    logic                    r_last;
    logic [PIX_W-1:0]        r_win [0:8];
    logic [PIX_W-1:0]        n_win [0:8];
    logic signed [GRAD_W-1:0] r_gx, r_gy, n_gx, n_gy;
    logic [SQ_W-1:0]         r_rem, n_rem;
    logic [SQ_W-1:0]         r_root, n_root;
    logic [SQ_W-1:0]         r_bit;
    logic                    r_out_valid;
    logic [PIX_W-1:0]        r_out_mag;
    logic                    r_out_last;

    logic [COL_W-1:0]        c_now;
    logic [IMG_H_W-1:0]      row_now;
    logic [IMG_W_W-1:0]      w_eff;
    logic [IMG_H_W-1:0]      h_eff;
    logic [CMP_W-1:0]        col_inc;
    logic [IMG_H_W:0]        row_inc;
    logic                    last_col;
    logic                    has_res;
    logic [PIX_W-1:0]        top_rd, mid_rd;
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SQ_W-1:0]         sq_sum;
    logic [SQ_W-1:0]         trial;

    // position of this request, frame start restarts the raster
    assign c_now   = i_frame_start ? '0 : r_col;
    assign row_now = i_frame_start ? '0 : r_row;

    always_comb begin
        if (r_img_w < IMG_W_W'(MIN_DIM)) begin
            w_eff = IMG_W_W'(MIN_DIM);
        end else if (r_img_w > IMG_W_W'(MAX_WIDTH)) begin
            w_eff = IMG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h < IMG_H_W'(MIN_DIM)) begin
            h_eff = IMG_H_W'(MIN_DIM);
        end else begin
            h_eff = r_img_h;
        end
    end

    assign col_inc  = CMP_W'(c_now) + CMP_W'(1);
    assign row_inc  = {1'b0, row_now} + (IMG_H_W+1)'(1);
    assign last_col = col_inc >= CMP_W'(w_eff);
    assign has_res  = (row_now >= IMG_H_W'(2)) && (c_now >= COL_W'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.capture) begin
            if (last_col) begin
                n_col = '0;
                n_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[IMG_H_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = row_now;
            end
        end
    end

    // line stores: top holds row r-2, mid holds row r-1
    sem_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_c),
        .i_wdata (mid_rd),
        .i_raddr (c_now),
        .o_rdata (top_rd)
    );

    sem_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_c),
        .i_wdata (r_pix),
        .i_raddr (c_now),
        .o_rdata (mid_rd)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]     = r_win[i*3+1];
            n_win[i*3 + 1] = r_win[i*3+2];
        end
        n_win[2] = top_rd;
        n_win[5] = mid_rd;
        n_win[8] = r_pix;
        n_gx = '0;
        n_gy = '0;
        for (int i = 0; i < 9; i++) begin
            n_gx = n_gx + sobel_term(n_win[i], KX[i]);
            n_gy = n_gy + sobel_term(n_win[i], KY[i]);
        end
    end

    assign gx_sq  = r_gx * r_gx;
    assign gy_sq  = r_gy * r_gy;
    assign sq_sum = SQ_W'($unsigned(gx_sq)) + SQ_W'($unsigned(gy_sq));

    // one result bit per step of the square root
    assign trial = r_root + r_bit;
    always_comb begin
        if (r_rem >= trial) begin
            n_rem  = r_rem - trial;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_rem  = r_rem;
            n_root = r_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= WIDTH_RESET;
            r_img_h     <= HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (i_cmd.load) begin
                for (int i = 0; i < 9; i++) begin
                    r_win[i] <= n_win[i];
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_mag_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_c       <= c_now;
            r_pix     <= i_pixel;
            r_has_res <= has_res;
            r_last    <= last_col;
        end
        if (i_cmd.load) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
        end
        if (i_cmd.square) begin
            r_rem  <= sq_sum;
            r_root <= '0;
            r_bit  <= ROOT_START;
        end else if (i_cmd.root_step) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bit  <= r_bit >> 2;
        end
        if (i_cmd.out_load) begin
            r_out_mag  <= (r_root > SQ_W'(MAG_MAX)) ? MAG_MAX : r_root[PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign o_stat.has_result = r_has_res;
    assign o_stat.root_last  = r_bit[0];
    assign o_stat.out_free   = !r_out_valid || i_mag_ready;

    assign o_mag_valid = r_out_valid;
    assign o_mag       = r_out_mag;
    assign o_row_last  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/sem_ctrl.sv
// controller state machine sequencing one pixel request through the datapath
`default_nettype none

module sem_ctrl import sem_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_sem_stat i_stat,
    output logic           o_in_ready,
    output t_sem_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_HOLD   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // line store data is back, window shifts and stores are written
                o_cmd.load = 1'b1;
                n_state    = i_stat.has_result ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_stat.root_last) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sem_checker.sv
// port-level checks for the sobel edge magnitude block and their bind
`default_nettype none

module sem_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_pix_valid,
    input wire logic       i_pix_ready,
    input wire logic       i_mag_valid,
    input wire logic       i_mag_ready,
    input wire logic [7:0] i_mag,
    input wire logic       i_row_last
);

    // one request at a time: the line store turnaround blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> !i_pix_ready)
        else $error("pixel request accepted back to back");

    // no result is loaded while an accepted request is still in its line store step
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready |=> ##1 !$rose(i_mag_valid))
        else $error("result appeared too early after a request");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mag_valid && !i_mag_ready |=> i_mag_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mag_valid && !i_mag_ready |=> $stable(i_mag) && $stable(i_row_last))
        else $error("result payload changed while stalled");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix.valid),
    .i_pix_ready (i_pix.ready),
    .i_mag_valid (o_mag.valid),
    .i_mag_ready (o_mag.ready),
    .i_mag       (o_mag.edge_magnitude),
    .i_row_last  (o_mag.row_last)
);

`default_nettype wire

>>> tb/sv/tb_sobel_edge_magnitude_top.sv
// self-checking testbench for the streaming sobel edge magnitude block
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_top;
    import sem_pkg::*;

    localparam int  ROW_LIMIT     = 4095;
    localparam int  RANDOM_ITEMS  = 540;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  HOLD_CYCLES   = 300;
    localparam int  DIR_ROWS      = 19;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       row_last;
    } t_edge;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
        bit         typed;
        bit         has_result;
        logic [7:0] magnitude;
        logic       row_last;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    sem_pix_if pix_ch ();
    sem_mag_if mag_ch ();

    sobel_edge_magnitude_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_mag      (mag_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // mirror of the block state
    logic [7:0]  line_rows [0:2*MAX_WIDTH-1];
    logic [7:0]  win [0:8];
    int          col_idx;
    int          row_idx;
    logic [10:0] cfg_width;
    logic [11:0] cfg_height;

    t_edge expected_edges [$];
    int    mismatches = 0;
    int    burst_left = 0;
    bit    hold_request = 1'b0;

    // zero frame, one stray pixel, then a left-edge frame that saturates the magnitude
    t_stim_row dir_table [DIR_ROWS] = '{
        '{8'd0,   1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b1, 8'd0,   1'b1},
        '{8'd128, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd255, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   1'b0, 1'b1, 1'b1, 8'd255, 1'b1}
    };

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(cfg_height);
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > ROW_LIMIT) h = ROW_LIMIT;
        return h;
    endfunction

    function automatic int quarter_floor(int v);
        return v >>> 2;
    endfunction

    task automatic compute_edge(input logic [7:0] p, input logic fs,
                                output bit produced, output t_edge res);
        int w, h, c, r, gx, gy, sq, m, i;
        logic [7:0] top, mid;
        w = eff_width();
        h = eff_height();
        if (fs) begin
            col_idx = 0;
            row_idx = 0;
        end
        c = col_idx;
        r = row_idx;
        top = line_rows[c];
        mid = line_rows[MAX_WIDTH + c];
        for (i = 0; i < 3; i++) begin
            win[i*3]     = win[i*3 + 1];
            win[i*3 + 1] = win[i*3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = p;
        line_rows[c] = mid;
        line_rows[MAX_WIDTH + c] = p;
        produced = 1'b0;
        res = '0;
        if (r >= 2 && c >= 2) begin
            gx = quarter_floor(-int'(win[0])) + quarter_floor(int'(win[2]))
               + quarter_floor(-2 * int'(win[3])) + quarter_floor(2 * int'(win[5]))
               + quarter_floor(-int'(win[6])) + quarter_floor(int'(win[8]));
            gy = quarter_floor(-int'(win[0])) + quarter_floor(-2 * int'(win[1]))
               + quarter_floor(-int'(win[2])) + quarter_floor(int'(win[6]))
               + quarter_floor(2 * int'(win[7])) + quarter_floor(int'(win[8]));
            sq = gx * gx + gy * gy;
            m = 0;
            while (m < 255 && (m + 1) * (m + 1) <= sq) m++;
            res.magnitude = m[7:0];
            res.row_last = (c + 1 >= w);
            produced = 1'b1;
        end
        if (c + 1 >= w) begin
            col_idx = 0;
            row_idx = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_idx = c + 1;
        end
    endtask

    function automatic logic [7:0] pick_pixel(int style, int base, int k);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2: begin
                v = base + $urandom_range(0, 8) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            default: v = base + k * 7;
        endcase
        return v[7:0];
    endfunction

    // one pixel request; the sender runs in bursts with random gaps between them
    task automatic send_pixel(input logic [7:0] p, input logic fs, input bit typed = 1'b0,
                              input bit typed_has = 1'b0, input t_edge typed_res = '0);
        bit produced;
        t_edge res;
        if (burst_left == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= p;
        pix_ch.frame_start <= fs;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        compute_edge(p, fs, produced, res);
        if (typed) begin
            if (typed_has) expected_edges.push_back(typed_res);
        end else if (produced) begin
            expected_edges.push_back(res);
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    // stop offering, let every expected result arrive, then allow for a pixel still in flight
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        while (expected_edges.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_IMAGE_WIDTH) cfg_width = data[10:0];
        else cfg_height = data[11:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // result receiver: stall pattern of its own, plus a long hold-off on request
    initial begin
        int mode = 0;
        int mode_left = 0;
        int phase = 0;
        mag_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                mag_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(64, 256);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: mag_ch.ready <= 1'b1;
                    1: mag_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: mag_ch.ready <= (phase % 3 == 0);
                    default: mag_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_edge want;
        if (i_rst_n && mag_ch.valid && mag_ch.ready) begin
            if (expected_edges.size() == 0) begin
                $error("unexpected result: edge_magnitude %0d row_last %0d",
                       mag_ch.edge_magnitude, mag_ch.row_last);
                mismatches++;
            end else begin
                want = expected_edges.pop_front();
                if (mag_ch.edge_magnitude !== want.magnitude) begin
                    $error("edge_magnitude mismatch: expected %0d, actual %0d",
                           want.magnitude, mag_ch.edge_magnitude);
                    mismatches++;
                end
                if (mag_ch.row_last !== want.row_last) begin
                    $error("row_last mismatch: expected %0d, actual %0d",
                           want.row_last, mag_ch.row_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int k, n, style, base, old_w;
        int random_items;
        bit restart, pressed;
        logic [CFG_W-1:0] wdata, hdata;
        random_items = 0;
        pressed = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        pix_ch.frame_start = 1'b0;
        for (k = 0; k < 2 * MAX_WIDTH; k++) line_rows[k] = '0;
        for (k = 0; k < 9; k++) win[k] = '0;
        col_idx = 0;
        row_idx = 0;
        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: two full rows and the start of a third, counts start from reset
        // without a frame marker; stall the output mid row so the input backs up
        for (k = 0; k < 2 * eff_width() + 40; k++) begin
            if (k == 2 * eff_width() + 10) hold_request = 1'b1;
            send_pixel(pick_pixel(0, 0, k), 1'b0);
        end

        // smallest frame, both registers below range
        drain_results();
        write_cfg(CFG_IMAGE_WIDTH, CFG_W'(0));
        write_cfg(CFG_IMAGE_HEIGHT, CFG_W'(2));
        foreach (dir_table[i])
            send_pixel(dir_table[i].pixel, dir_table[i].frame_start, dir_table[i].typed,
                       dir_table[i].has_result,
                       t_edge'{dir_table[i].magnitude, dir_table[i].row_last});

        while (random_items < RANDOM_ITEMS) begin
            drain_results();
            old_w = eff_width();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: wdata = CFG_W'($urandom_range(0, 2));
                    1: wdata = CFG_W'(3);
                    2, 3: wdata = CFG_W'($urandom_range(17, 80));
                    default: wdata = CFG_W'($urandom_range(4, 16));
                endcase
                write_cfg(CFG_IMAGE_WIDTH, wdata);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: hdata = CFG_W'($urandom_range(0, 2));
                    1: hdata = CFG_W'(ROW_LIMIT);
                    2: hdata = CFG_W'($urandom_range(0, ROW_LIMIT));
                    3: hdata = CFG_W'($urandom_range(9, 40));
                    default: hdata = CFG_W'($urandom_range(3, 8));
                endcase
                write_cfg(CFG_IMAGE_HEIGHT, hdata);
            end
            // a wider row would read line store columns not yet written in this frame
            restart = eff_width() > old_w;
            style = $urandom_range(0, 3);
            base = $urandom_range(0, 255);
            n = $urandom_range(1, eff_width() * 6);
            if (n > 200) n = 200;
            for (k = 0; k < n; k++) begin
                if (!pressed && random_items > RANDOM_ITEMS / 2 && k == n / 2) begin
                    hold_request = 1'b1;
                    pressed = 1'b1;
                end
                send_pixel(pick_pixel(style, base, k),
                           (k == 0 && restart) || ($urandom_range(0, 63) == 0));
                random_items++;
            end
        end

        drain_results();
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sem_pkg.sv
rtl/sem_pix_if.sv
rtl/sem_mag_if.sv
rtl/sem_ram.sv
rtl/sem_dp.sv
rtl/sem_ctrl.sv
rtl/sobel_edge_magnitude_top.sv
rtl/sem_checker.sv
tb/sv/tb_sobel_edge_magnitude_top.sv
